/* hw/rtl/poc_pkg.sv */
package poc_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int CHAR_W      = 8;
    localparam int HIT_W       = 16;
    localparam int REG_COUNT   = 8;
    localparam int REG_W       = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int WIN_W       = MAX_PATTERN * CHAR_W;
    localparam int PAT_W       = REG_COUNT * REG_W;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              text_start;
    } in_t;

    typedef struct packed {
        logic             match_found;
        logic [HIT_W-1:0] hit_total;
    } out_t;

    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [MAX_PATTERN-1:0] mask;
        logic [WIN_W-1:0]       expect_bytes;
    } pat_cfg_t;

endpackage

/* hw/rtl/pattern_occurrence_counter.sv */
// A result is offered once its request has passed the input register and then
// the result register, and is taken on an edge where m_ready is high.
// Throughput: one request per cycle while the receiver takes results; the
// single compare stage over the character window sets it. A result held by
// the receiver holds the input register; intake stalls once it is full too.
// Reset (aresetn low, synchronous) clears the search word, window, counts
// and both valid flags.
module pattern_occurrence_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  poc_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output poc_pkg::out_t                   m_data,
    input  logic                            cfg_wr_en,
    input  logic [poc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [poc_pkg::REG_W-1:0]       cfg_wdata
);

    poc_pkg::pat_cfg_t pat_cfg;
    poc_pkg::in_t      in_reg;
    logic              in_valid_reg;
    poc_pkg::out_t     out_reg;
    logic              out_valid_reg;
    poc_pkg::out_t     result;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    poc_pattern u_pattern (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pat_cfg   (pat_cfg)
    );

    poc_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .pat_cfg (pat_cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/poc_pattern.sv */
module poc_pattern (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [poc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [poc_pkg::REG_W-1:0]       cfg_wdata,
    output poc_pkg::pat_cfg_t               pat_cfg
);

    logic [poc_pkg::REG_W-1:0] word_reg  [poc_pkg::REG_COUNT];
    logic [poc_pkg::REG_W-1:0] word_next [poc_pkg::REG_COUNT];
    logic [poc_pkg::PAT_W-1:0] word_flat;
    logic [poc_pkg::WIN_W-1:0] rev_flat;
    logic [poc_pkg::WIN_W-1:0] shifted;
    logic [poc_pkg::LEN_W-1:0] len_next;
    logic [poc_pkg::LEN_W-1:0] shift_amt;
    poc_pkg::pat_cfg_t         cfg_reg;
    poc_pkg::pat_cfg_t         cfg_next;

    for (genvar r = 0; r < poc_pkg::REG_COUNT; r++) begin : g_word
        assign word_next[r] = (cfg_wr_en && cfg_index == poc_pkg::CFG_IDX_W'(r)) ?
                              cfg_wdata : word_reg[r];
        assign word_flat[r*poc_pkg::REG_W +: poc_pkg::REG_W] = word_next[r];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                word_reg[r] <= '0;
            end else begin
                word_reg[r] <= word_next[r];
            end
        end
    end

    // reverse the word so that the last character lands in window slot 0
    always_comb begin
        len_next = poc_pkg::LEN_W'(poc_pkg::MAX_PATTERN);
        for (int k = poc_pkg::MAX_PATTERN - 1; k >= 0; k--) begin
            if (word_flat[k*poc_pkg::CHAR_W +: poc_pkg::CHAR_W] == '0) begin
                len_next = poc_pkg::LEN_W'(k);
            end
        end
        for (int j = 0; j < poc_pkg::MAX_PATTERN; j++) begin
            rev_flat[j*poc_pkg::CHAR_W +: poc_pkg::CHAR_W] =
                word_flat[(poc_pkg::MAX_PATTERN-1-j)*poc_pkg::CHAR_W +: poc_pkg::CHAR_W];
        end
    end

    assign shift_amt = poc_pkg::LEN_W'(poc_pkg::MAX_PATTERN) - len_next;
    assign shifted   = rev_flat >> {shift_amt, 3'b000};

    always_comb begin
        cfg_next.len          = len_next;
        cfg_next.expect_bytes = shifted;
        for (int i = 0; i < poc_pkg::MAX_PATTERN; i++) begin
            cfg_next.mask[i] = (poc_pkg::LEN_W'(i) < len_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign pat_cfg = cfg_reg;

endmodule

/* hw/rtl/poc_match.sv */
module poc_match (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  poc_pkg::in_t      item,
    input  poc_pkg::pat_cfg_t pat_cfg,
    output poc_pkg::out_t     result
);

    logic [poc_pkg::WIN_W-1:0]       window_reg;
    logic [poc_pkg::WIN_W-1:0]       window_next;
    logic [poc_pkg::WIN_W-1:0]       window_base;
    logic [poc_pkg::LEN_W-1:0]       since_reg;
    logic [poc_pkg::LEN_W-1:0]       since_next;
    logic [poc_pkg::LEN_W-1:0]       since_base;
    logic [poc_pkg::LEN_W-1:0]       since_inc;
    logic [poc_pkg::HIT_W-1:0]       hits_reg;
    logic [poc_pkg::HIT_W-1:0]       hits_next;
    logic [poc_pkg::HIT_W-1:0]       hits_base;
    logic [poc_pkg::MAX_PATTERN-1:0] slot_ok;
    logic                            hit;

    assign window_base = item.text_start ? '0 : window_reg;
    assign window_next = (window_base << poc_pkg::CHAR_W) |
                         poc_pkg::WIN_W'(item.text_char);

    always_comb begin
        for (int i = 0; i < poc_pkg::MAX_PATTERN; i++) begin
            slot_ok[i] = !pat_cfg.mask[i] ||
                (window_next[i*poc_pkg::CHAR_W +: poc_pkg::CHAR_W] ==
                 pat_cfg.expect_bytes[i*poc_pkg::CHAR_W +: poc_pkg::CHAR_W]);
        end
    end

    assign since_base = item.text_start ? '0 : since_reg;
    assign since_inc  = (since_base < poc_pkg::LEN_W'(poc_pkg::MAX_PATTERN)) ?
                        since_base + 1'b1 : since_base;
    assign hit        = (pat_cfg.len != '0) && (since_inc >= pat_cfg.len) && (&slot_ok);
    assign since_next = hit ? '0 : since_inc;

    assign hits_base = item.text_start ? '0 : hits_reg;
    assign hits_next = (hit && hits_base != '1) ? hits_base + 1'b1 : hits_base;

    assign result.match_found = hit;
    assign result.hit_total   = hits_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            since_reg  <= '0;
            hits_reg   <= '0;
        end else if (advance) begin
            window_reg <= window_next;
            since_reg  <= since_next;
            hits_reg   <= hits_next;
        end
    end

`ifndef ASSERT_OFF
    a_hit_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && hit |-> pat_cfg.len != '0)
        else $error("hit reported with empty word");

    a_hit_restarts_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && hit |=> since_reg == '0)
        else $error("character count not restarted after hit");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        since_reg <= poc_pkg::LEN_W'(poc_pkg::MAX_PATTERN))
        else $error("character count beyond word limit");

    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.text_start |=> hits_reg >= $past(hits_reg))
        else $error("hit count decreased without text start");

    a_mask_matches_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(pat_cfg.mask) == int'(pat_cfg.len))
        else $error("compare mask disagrees with word length");
`endif

endmodule
